/* design/dcf_pkg.sv */
// Shared types and constants for the depth centroid follower.
`default_nettype none
package dcf_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_WIN_LEFT   = 3'd0;
  localparam logic [2:0] CFG_WIN_RIGHT  = 3'd1;
  localparam logic [2:0] CFG_WIN_TOP    = 3'd2;
  localparam logic [2:0] CFG_WIN_BOTTOM = 3'd3;
  localparam logic [2:0] CFG_GOAL_DEPTH = 3'd4;
  localparam logic [2:0] CFG_DEPTH_LIM  = 3'd5;
  localparam logic [2:0] CFG_MIN_HITS   = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Reset values of the configuration registers
  localparam logic [8:0]  RST_WIN_LEFT   = 9'd80;
  localparam logic [8:0]  RST_WIN_RIGHT  = 9'd240;
  localparam logic [7:0]  RST_WIN_TOP    = 8'd40;
  localparam logic [7:0]  RST_WIN_BOTTOM = 8'd200;
  localparam logic [15:0] RST_GOAL_DEPTH = 16'd600;
  localparam logic [15:0] RST_DEPTH_LIM  = 16'd900;
  localparam logic [16:0] RST_MIN_HITS   = 17'd1000;

  // Field and accumulator widths
  localparam int DEPTH_W = 16;
  localparam int CNT_W   = 17;
  localparam int CSUM_W  = 25;
  localparam int DSUM_W  = 33;
  localparam int LIN_W   = 19;
  localparam int ANG_W   = 13;
  localparam int AVGC_W  = 9;   // average column stays below window_right
  localparam int GAIN_W  = 11;  // gains up to 1024

  // Restoring divider runs one quotient bit per cycle over the widest sum
  localparam int DIV_STEPS = DSUM_W;
  localparam int STEP_W    = 6;

  localparam int LIN_MAX = 262143;
  localparam int LIN_MIN = -262144;
  localparam int ANG_MAX = 4095;
  localparam int ANG_MIN = -4096;

  typedef struct packed {
    logic acc;       // accumulate the accepted pixel, advance position
    logic div_load;  // load divider with the frame sums
    logic div_step;  // one divider iteration
    logic mul;       // register gain products
    logic emit;      // load result register, update held speeds, clear sums
    logic seen;      // frame produced new speeds
  } dcf_cmd_t;

  typedef struct packed {
    logic target_ok; // hit count above threshold
  } dcf_stat_t;

endpackage
`default_nettype wire

/* design/dcf_if.sv */
// Valid/ready channel interfaces for pixels/commands in and speed results out.
`default_nettype none
interface dcf_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] depth;
  logic        frame_end;
  logic        resume_cmd;

  modport source (output valid, func, depth, frame_end, resume_cmd, input ready);
  modport sink   (input valid, func, depth, frame_end, resume_cmd, output ready);
endinterface

interface dcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] linear_speed;
  logic signed [12:0] angular_speed;
  logic               target_seen;

  modport source (output valid, linear_speed, angular_speed, target_seen, input ready);
  modport sink   (input valid, linear_speed, angular_speed, target_seen, output ready);
endinterface
`default_nettype wire

/* design/depth_centroid_follower.sv */
// Top level of the depth centroid follower: controller plus datapath.
// Pixels and pause/resume commands are taken one per cycle. The frame-end pixel
// starts a result sequence during which in_ch.ready is low: a hit count check,
// then, if a target is seen, the bit-serial divider that forms the average column
// and depth, a multiply step and the result register load, which waits while the
// previous result is still held in the output register. The block comes out of
// reset paused; a command item with resume_cmd set starts it. Configuration must
// be written through cfg_we/cfg_index/cfg_data while no frame is in progress;
// the block itself does not enforce this.
`default_nettype none
module depth_centroid_follower #(
  parameter int IMAGE_WIDTH  = 320,
  parameter int IMAGE_HEIGHT = 240,
  parameter int LIN_GAIN     = 256,
  parameter int ANG_GAIN     = 256
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  dcf_in_if.sink                              in_ch,
  dcf_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dcf_pkg::CFG_DATA_W-1:0] cfg_data
);

  dcf_pkg::dcf_cmd_t  cmd;
  dcf_pkg::dcf_stat_t stat;

  dcf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_func       (in_ch.func),
    .in_frame_end  (in_ch.frame_end),
    .in_resume_cmd (in_ch.resume_cmd),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  dcf_datapath #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .LIN_GAIN     (LIN_GAIN),
    .ANG_GAIN     (ANG_GAIN)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_depth          (in_ch.depth),
    .in_frame_end      (in_ch.frame_end),
    .cmd               (cmd),
    .stat              (stat),
    .out_linear_speed  (out_ch.linear_speed),
    .out_angular_speed (out_ch.angular_speed),
    .out_target_seen   (out_ch.target_seen)
  );

endmodule
`default_nettype wire

/* design/dcf_ctrl.sv */
// Controller: pause state, frame-end sequencing of divide, multiply and emit.
`default_nettype none
module dcf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic               in_frame_end,
  input  wire logic               in_resume_cmd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire dcf_pkg::dcf_stat_t stat,
  output dcf_pkg::dcf_cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [dcf_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         paused_r, paused_nxt;
  logic                         seen_r, seen_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         in_xfer;
  logic                         out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    paused_nxt   = paused_r;
    seen_nxt     = seen_r;
    cmd          = '0;
    cmd.seen     = seen_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_func) begin
            paused_nxt = !in_resume_cmd;
          end else if (!paused_r) begin
            cmd.acc = 1'b1;
            if (in_frame_end) begin
              state_nxt = ST_EVAL;
            end
          end
        end
      end
      ST_EVAL: begin
        seen_nxt = stat.target_ok;
        if (stat.target_ok) begin
          cmd.div_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == dcf_pkg::STEP_W'(dcf_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      paused_r    <= 1'b1;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      paused_r    <= paused_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/dcf_datapath.sv */
// Datapath: config registers, raster position, accumulators, divider, gains, result register.
`default_nettype none
module dcf_datapath #(
  parameter int IMAGE_WIDTH  = 320,
  parameter int IMAGE_HEIGHT = 240,
  parameter int LIN_GAIN     = 256,
  parameter int ANG_GAIN     = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dcf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [dcf_pkg::DEPTH_W-1:0]      in_depth,
  input  wire logic                             in_frame_end,
  input  wire dcf_pkg::dcf_cmd_t                cmd,
  output dcf_pkg::dcf_stat_t                    stat,
  output logic signed [dcf_pkg::LIN_W-1:0]      out_linear_speed,
  output logic signed [dcf_pkg::ANG_W-1:0]      out_angular_speed,
  output logic                                  out_target_seen
);

  localparam int COL_W  = $clog2(IMAGE_WIDTH + 1);
  localparam int ROW_W  = $clog2(IMAGE_HEIGHT + 1);
  localparam int CCMP_W = (COL_W > 9) ? COL_W : 9;
  localparam int RCMP_W = (ROW_W > 8) ? ROW_W : 8;
  localparam int HALF_W = IMAGE_WIDTH / 2;
  localparam int CNT_W  = dcf_pkg::CNT_W;
  localparam int DSUM_W = dcf_pkg::DSUM_W;
  localparam int CSUM_W = dcf_pkg::CSUM_W;
  localparam int DEP_W  = dcf_pkg::DEPTH_W;
  localparam int AVGC_W = dcf_pkg::AVGC_W;
  localparam int LDIF_W = DEP_W + 2;
  localparam int ADIF_W = 12;
  localparam int LPRD_W = LDIF_W + dcf_pkg::GAIN_W + 1;
  localparam int APRD_W = ADIF_W + dcf_pkg::GAIN_W + 1;

  // Configuration
  logic [8:0]       win_left_r, win_right_r;
  logic [7:0]       win_top_r, win_bottom_r;
  logic [DEP_W-1:0] goal_r, depth_lim_r;
  logic [CNT_W-1:0] min_hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= dcf_pkg::RST_WIN_LEFT;
      win_right_r  <= dcf_pkg::RST_WIN_RIGHT;
      win_top_r    <= dcf_pkg::RST_WIN_TOP;
      win_bottom_r <= dcf_pkg::RST_WIN_BOTTOM;
      goal_r       <= dcf_pkg::RST_GOAL_DEPTH;
      depth_lim_r  <= dcf_pkg::RST_DEPTH_LIM;
      min_hits_r   <= dcf_pkg::RST_MIN_HITS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcf_pkg::CFG_WIN_LEFT:   win_left_r   <= cfg_data[8:0];
        dcf_pkg::CFG_WIN_RIGHT:  win_right_r  <= cfg_data[8:0];
        dcf_pkg::CFG_WIN_TOP:    win_top_r    <= cfg_data[7:0];
        dcf_pkg::CFG_WIN_BOTTOM: win_bottom_r <= cfg_data[7:0];
        dcf_pkg::CFG_GOAL_DEPTH: goal_r       <= cfg_data[15:0];
        dcf_pkg::CFG_DEPTH_LIM:  depth_lim_r  <= cfg_data[15:0];
        dcf_pkg::CFG_MIN_HITS:   min_hits_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Raster position and accumulators
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CSUM_W-1:0] csum_r, csum_nxt;
  logic [DSUM_W-1:0] dsum_r, dsum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CCMP_W-1:0] col_x;
  logic [RCMP_W-1:0] row_x;
  logic              in_win, is_hit, fits;
  logic [CSUM_W:0]   csum_add;
  logic [DSUM_W:0]   dsum_add;

  assign col_x  = CCMP_W'(col_r);
  assign row_x  = RCMP_W'(row_r);
  assign in_win = (col_x >= CCMP_W'(win_left_r)) && (col_x < CCMP_W'(win_right_r)) &&
                  (row_x >= RCMP_W'(win_top_r)) && (row_x < RCMP_W'(win_bottom_r));
  assign is_hit = in_win && (in_depth < depth_lim_r);

  assign csum_add = {1'b0, csum_r} + (CSUM_W + 1)'(col_r);
  assign dsum_add = {1'b0, dsum_r} + (DSUM_W + 1)'(in_depth);
  // hits that would overflow any accumulator are dropped
  assign fits = (cnt_r != {CNT_W{1'b1}}) && !csum_add[CSUM_W] && !dsum_add[DSUM_W];

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    csum_nxt = csum_r;
    dsum_nxt = dsum_r;
    cnt_nxt  = cnt_r;
    if (cmd.acc) begin
      if (is_hit && fits) begin
        csum_nxt = csum_add[CSUM_W-1:0];
        dsum_nxt = dsum_add[DSUM_W-1:0];
        cnt_nxt  = cnt_r + 1'b1;
      end
      if (in_frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == COL_W'(IMAGE_WIDTH - 1)) begin
        col_nxt = '0;
        row_nxt = (row_r == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end else if (cmd.emit) begin
      csum_nxt = '0;
      dsum_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      csum_r <= '0;
      dsum_r <= '0;
      cnt_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      csum_r <= csum_nxt;
      dsum_r <= dsum_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign stat.target_ok = (cnt_r > min_hits_r);

  // Two restoring dividers sharing the hit count as divisor, one bit per cycle.
  // Quotients fit their short registers, so only low bits are kept.
  logic [DSUM_W-1:0] dd_r, cd_r;
  logic [CNT_W-1:0]  drem_r, crem_r;
  logic [DEP_W-1:0]  dq_r;
  logic [AVGC_W-1:0] cq_r;
  logic [CNT_W:0]    dtrial, ctrial;
  logic              dge, cge;

  assign dtrial = {drem_r, dd_r[DSUM_W-1]};
  assign ctrial = {crem_r, cd_r[DSUM_W-1]};
  assign dge    = (dtrial >= {1'b0, cnt_r});
  assign cge    = (ctrial >= {1'b0, cnt_r});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dd_r   <= dsum_r;
      cd_r   <= DSUM_W'(csum_r);
      drem_r <= '0;
      crem_r <= '0;
      dq_r   <= '0;
      cq_r   <= '0;
    end else if (cmd.div_step) begin
      dd_r   <= {dd_r[DSUM_W-2:0], 1'b0};
      cd_r   <= {cd_r[DSUM_W-2:0], 1'b0};
      drem_r <= dge ? CNT_W'(dtrial - {1'b0, cnt_r}) : dtrial[CNT_W-1:0];
      crem_r <= cge ? CNT_W'(ctrial - {1'b0, cnt_r}) : ctrial[CNT_W-1:0];
      dq_r   <= {dq_r[DEP_W-2:0], dge};
      cq_r   <= {cq_r[AVGC_W-2:0], cge};
    end
  end

  // Gain products
  logic signed [LDIF_W-1:0] lin_diff;
  logic signed [ADIF_W-1:0] ang_diff;
  logic signed [LPRD_W-1:0] lin_prod_r, lin_a, lin_g;
  logic signed [APRD_W-1:0] ang_prod_r, ang_a, ang_g;

  assign lin_diff = $signed({2'b00, dq_r}) - $signed({2'b00, goal_r});
  assign ang_diff = $signed(ADIF_W'(HALF_W)) - $signed(ADIF_W'(cq_r));
  assign lin_a    = LPRD_W'(lin_diff);
  assign ang_a    = APRD_W'(ang_diff);
  assign lin_g    = $signed(LPRD_W'(LIN_GAIN));
  assign ang_g    = $signed(APRD_W'(ANG_GAIN));

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      lin_prod_r <= lin_a * lin_g;
      ang_prod_r <= ang_a * ang_g;
    end
  end

  // Floor shift by 8 and saturation
  logic signed [LPRD_W-1:0] lin_sh;
  logic signed [APRD_W-1:0] ang_sh;
  logic signed [dcf_pkg::LIN_W-1:0] lin_sat;
  logic signed [dcf_pkg::ANG_W-1:0] ang_sat;

  assign lin_sh = lin_prod_r >>> 8;
  assign ang_sh = ang_prod_r >>> 8;

  always_comb begin
    if (lin_sh > LPRD_W'(dcf_pkg::LIN_MAX)) begin
      lin_sat = dcf_pkg::LIN_W'(dcf_pkg::LIN_MAX);
    end else if (lin_sh < $signed(LPRD_W'(dcf_pkg::LIN_MIN))) begin
      lin_sat = dcf_pkg::LIN_W'(dcf_pkg::LIN_MIN);
    end else begin
      lin_sat = lin_sh[dcf_pkg::LIN_W-1:0];
    end
    if (ang_sh > APRD_W'(dcf_pkg::ANG_MAX)) begin
      ang_sat = dcf_pkg::ANG_W'(dcf_pkg::ANG_MAX);
    end else if (ang_sh < $signed(APRD_W'(dcf_pkg::ANG_MIN))) begin
      ang_sat = dcf_pkg::ANG_W'(dcf_pkg::ANG_MIN);
    end else begin
      ang_sat = ang_sh[dcf_pkg::ANG_W-1:0];
    end
  end

  // Held speeds and result register
  logic signed [dcf_pkg::LIN_W-1:0] held_lin_r, out_lin_r;
  logic signed [dcf_pkg::ANG_W-1:0] held_ang_r, out_ang_r;
  logic                             out_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lin_r <= '0;
      held_ang_r <= '0;
    end else if (cmd.emit && cmd.seen) begin
      held_lin_r <= lin_sat;
      held_ang_r <= ang_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_lin_r  <= cmd.seen ? lin_sat : held_lin_r;
      out_ang_r  <= cmd.seen ? ang_sat : held_ang_r;
      out_seen_r <= cmd.seen;
    end
  end

  assign out_linear_speed  = out_lin_r;
  assign out_angular_speed = out_ang_r;
  assign out_target_seen   = out_seen_r;

endmodule
`default_nettype wire

/* design/dcf_checker.sv */
// Port-level checker for the depth centroid follower, bound to the top level.
`default_nettype none
module dcf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_func,
  input wire logic        in_frame_end,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [18:0] out_linear_speed,
  input wire logic [12:0] out_angular_speed,
  input wire logic        out_target_seen
);

  // no result can be pending right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // commands and non-final pixels never stall the input side
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func || !in_frame_end)) |=> in_ready)
    else $error("input stalled after a non-frame-end transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_linear_speed) &&
      $stable(out_angular_speed) && $stable(out_target_seen)))
    else $error("result changed while stalled");

endmodule

bind depth_centroid_follower dcf_checker u_dcf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_func           (in_ch.func),
  .in_frame_end      (in_ch.frame_end),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_linear_speed  (out_ch.linear_speed),
  .out_angular_speed (out_ch.angular_speed),
  .out_target_seen   (out_ch.target_seen)
);
`default_nettype wire
